/* rtl/rps_pkg.sv */
// ----------------------------------------------------------------------------
// rps_pkg
// Shared types and constants for the relay power sequencer.
// ----------------------------------------------------------------------------
package rps_pkg;

	localparam int NUM_CHANNELS_DEF = 8;
	localparam int STEP_MS          = 100;
	localparam int MS_PER_SEC       = 1000;
	localparam int CNT_W            = 16;
	localparam int DELAY_BITS       = 7;
	localparam int CFG_W            = 56;
	localparam int CFG_IDX_W        = 2;
	localparam int RELAY_OUT_W      = 8;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LINK_MODE    = 2'd0,
		REG_OPEN_DELAYS  = 2'd1,
		REG_CLOSE_DELAYS = 2'd2
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ST_ALL_OFF = 2'd0,
		ST_ALL_ON  = 2'd1,
		ST_MIXED   = 2'd2
	} seq_status_t;

endpackage

/* rtl/relay_power_sequencer_top.sv */
// ----------------------------------------------------------------------------
// relay_power_sequencer_top
// Relay on/off sequencer stepped by one timer tick per input transfer.
//
// Channels: the input channel (in_valid/in_ready) carries one tick with the
// requested direction, the NEXT pin level and the delay mark. The output
// channel (out_valid/out_ready) returns one result per tick: the relay bits,
// the all-off/all-on/mixed status and the linked-mode close hold flag.
// Timing: the result is registered and presented in the cycle after the
// input transfer. Throughput: one tick per cycle unless stalled; the
// sequencer state registers double as the result register, so a new tick
// is taken in the same cycle the pending result is taken.
// Stall: while a result waits and out_ready is low, in_ready is low and the
// state holds.
// Reset: relays off, counters, hold and pending marks cleared, free mode,
// all delays zero. Configuration writes (cfg_wr_en) take effect at once and
// must be issued only while no tick is in flight; the block does not check.
// ----------------------------------------------------------------------------
module relay_power_sequencer_top #(
	parameter int NUM_CHANNELS = rps_pkg::NUM_CHANNELS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wr_en,
	input  logic [rps_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [rps_pkg::CFG_W-1:0]      cfg_data,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic                           open_request,
	input  logic                           next_level,
	input  logic                           delay_start,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [rps_pkg::RELAY_OUT_W-1:0] relay_bits,
	output logic [1:0]                     sequence_status,
	output logic                           close_held
);

	localparam int CNT_W  = rps_pkg::CNT_W;
	localparam int DB     = rps_pkg::DELAY_BITS;
	localparam int EXT_W  = (NUM_CHANNELS > rps_pkg::RELAY_OUT_W) ?
		NUM_CHANNELS : rps_pkg::RELAY_OUT_W;
	localparam logic [CNT_W-1:0] LINK_SPAN = CNT_W'(NUM_CHANNELS * rps_pkg::MS_PER_SEC);
	localparam logic [CNT_W-1:0] STEP      = CNT_W'(rps_pkg::STEP_MS);

	// configuration
	logic                      link_q;
	logic [rps_pkg::CFG_W-1:0] open_dly_q;
	logic [rps_pkg::CFG_W-1:0] close_dly_q;

	// sequencer state
	logic [NUM_CHANNELS-1:0]   relay_q;
	rps_pkg::seq_status_t      status_q;
	logic [CNT_W-1:0]          open_cnt_q;
	logic [CNT_W-1:0]          close_cnt_q;
	logic                      last_on_q;
	logic                      pend_q;
	logic                      hold_q;
	logic                      out_valid_q;

	logic                      in_xfer;
	logic                      pend_in;
	logic [rps_pkg::CFG_W-1:0] dly_sel;
	logic [CNT_W-1:0]          cnt_cur;
	logic [CNT_W-1:0]          cnt_adv;
	logic [CNT_W-1:0]          cnt_other;
	logic [DB-1:0]             sec;
	logic [CNT_W-1:0]          tgt;
	logic [NUM_CHANNELS-1:0]   match;
	logic [NUM_CHANNELS-1:0]   relay_adv;
	logic                      last_hit;
	logic                      hold_pre;
	logic                      hold_post;
	logic                      step_en;
	logic                      last_on_a;
	logic                      pend_a;
	rps_pkg::seq_status_t      status_adv;

	logic [NUM_CHANNELS-1:0]   relay_n;
	rps_pkg::seq_status_t      status_n;
	logic [CNT_W-1:0]          open_cnt_n;
	logic [CNT_W-1:0]          close_cnt_n;
	logic                      last_on_n;
	logic                      pend_n;
	logic                      hold_n;
	logic [EXT_W-1:0]          relay_ext;

	assign in_ready = !out_valid_q || out_ready;
	assign in_xfer  = in_valid && in_ready;

	always_comb begin
		pend_in = pend_q | delay_start;
		dly_sel = open_request ? open_dly_q : close_dly_q;
		cnt_cur = open_request ? open_cnt_q : close_cnt_q;
		cnt_adv = cnt_cur + STEP;
		cnt_other = link_q ? (LINK_SPAN - cnt_adv) : '0;

		for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
			sec = DB'(dly_sel >> (ch * DB));
			if (link_q) begin
				tgt = open_request ? CNT_W'((ch + 1) * rps_pkg::MS_PER_SEC) :
					CNT_W'((NUM_CHANNELS - ch) * rps_pkg::MS_PER_SEC);
			end else begin
				tgt = CNT_W'(int'(sec) * rps_pkg::MS_PER_SEC);
			end
			match[ch] = (cnt_adv == tgt);
		end

		relay_adv = open_request ? (relay_q | match) : (relay_q & ~match);
		last_hit  = match[NUM_CHANNELS-1];

		if (&relay_adv) begin
			status_adv = rps_pkg::ST_ALL_ON;
		end else if (~|relay_adv) begin
			status_adv = rps_pkg::ST_ALL_OFF;
		end else begin
			status_adv = rps_pkg::ST_MIXED;
		end

		// hold as seen before any step (closing path)
		hold_pre = pend_in ? 1'b0 : ((next_level && last_on_q) ? 1'b1 : hold_q);

		if (open_request) begin
			step_en = (status_q != rps_pkg::ST_ALL_ON);
		end else begin
			step_en = (status_q != rps_pkg::ST_ALL_OFF) && !(link_q && hold_pre);
		end

		last_on_a = (step_en && last_hit) ? open_request : last_on_q;
		pend_a    = (step_en && last_hit) ? 1'b0 : pend_in;

		// hold as seen after the opening step
		hold_post = pend_a ? 1'b0 : ((next_level && last_on_a) ? 1'b1 : hold_q);

		hold_n      = link_q ? (open_request ? hold_post : hold_pre) : hold_q;
		last_on_n   = last_on_a;
		pend_n      = pend_a;
		relay_n     = relay_q;
		status_n    = status_q;
		open_cnt_n  = open_cnt_q;
		close_cnt_n = close_cnt_q;
		if (step_en) begin
			relay_n  = relay_adv;
			status_n = status_adv;
			if (open_request) begin
				open_cnt_n  = cnt_adv;
				close_cnt_n = cnt_other;
			end else begin
				close_cnt_n = cnt_adv;
				open_cnt_n  = cnt_other;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			link_q      <= 1'b0;
			open_dly_q  <= '0;
			close_dly_q <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				rps_pkg::REG_LINK_MODE:    link_q      <= cfg_data[0];
				rps_pkg::REG_OPEN_DELAYS:  open_dly_q  <= cfg_data;
				rps_pkg::REG_CLOSE_DELAYS: close_dly_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			relay_q     <= '0;
			status_q    <= rps_pkg::ST_ALL_OFF;
			open_cnt_q  <= '0;
			close_cnt_q <= '0;
			last_on_q   <= 1'b0;
			pend_q      <= 1'b0;
			hold_q      <= 1'b0;
		end else if (in_xfer) begin
			relay_q     <= relay_n;
			status_q    <= status_n;
			open_cnt_q  <= open_cnt_n;
			close_cnt_q <= close_cnt_n;
			last_on_q   <= last_on_n;
			pend_q      <= pend_n;
			hold_q      <= hold_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_xfer) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign relay_ext       = EXT_W'(relay_q);
	assign relay_bits      = relay_ext[rps_pkg::RELAY_OUT_W-1:0];
	assign sequence_status = status_q;
	assign close_held      = hold_q;
	assign out_valid       = out_valid_q;

	// status always agrees with the relay pattern
	a_status_off: assert property (@(posedge clk) disable iff (!arst_n)
		(status_q == rps_pkg::ST_ALL_OFF) == (relay_q == '0))
		else $error("status all-off disagrees with relays");

	a_status_on: assert property (@(posedge clk) disable iff (!arst_n)
		(status_q == rps_pkg::ST_ALL_ON) == (&relay_q))
		else $error("status all-on disagrees with relays");

	// state moves only on an input transfer
	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!in_xfer |=> $stable(relay_q) && $stable(hold_q) && $stable(open_cnt_q)
			&& $stable(close_cnt_q))
		else $error("sequencer state changed without a transfer");

	// a stalled result is never overwritten
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ready |-> !in_xfer)
		else $error("input transfer while result stalled");

endmodule
